FILE: rtl/fsec_pkg.sv
// ----------------------------------------------------------------------------
// fsec_pkg
// Shared constants for the binary32/binary64 significand-exponent codec.
// ----------------------------------------------------------------------------
package fsec_pkg;

    // Format constants
    localparam int SP_BIAS = 127;
    localparam int DP_BIAS = 1023;
    localparam int SP_FRAC = 23;
    localparam int DP_FRAC = 52;
    localparam int SP_EXPW = 8;
    localparam int DP_EXPW = 11;

    // Field widths
    localparam int FLOAT_W = 64;
    localparam int SIG_W   = 64;
    localparam int EXPI_W  = 16;
    localparam int EXPO_W  = 12;

    // Stream widths
    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 144;
    localparam int S_TUSER_W = 2;

    // Operation codes
    localparam logic OP_UNPACK = 1'b0;
    localparam logic OP_PACK   = 1'b1;

endpackage

FILE: rtl/fsec_unpack.sv
// ----------------------------------------------------------------------------
// fsec_unpack
// Splits an IEEE pattern into a signed significand and an exponent.
// ----------------------------------------------------------------------------
module fsec_unpack
    import fsec_pkg::*;
(
    input  logic                      precision,
    input  logic [FLOAT_W-1:0]        float_bits,
    output logic signed [SIG_W-1:0]   significand_out,
    output logic signed [EXPO_W-1:0]  exponent_out
);

    logic        neg;
    logic [10:0] expf;
    logic [51:0] frac;
    logic        exp_ones;
    logic [63:0] smax;
    logic [63:0] mag;
    logic signed [12:0] e_norm;
    logic signed [12:0] e_sub;

    // Pick fields by format
    always_comb
    begin
        if (precision)
        begin
            neg      = float_bits[63];
            expf     = float_bits[62:52];
            frac     = float_bits[51:0];
            exp_ones = (float_bits[62:52] == 11'h7FF);
            smax     = 64'h7FFF_FFFF_FFFF_FFFF;
            mag      = {11'd0, 1'b1, float_bits[51:0]};
            e_norm   = $signed({2'b00, float_bits[62:52]}) - 13'(DP_BIAS + DP_FRAC);
            e_sub    = 13'(1 - DP_BIAS - DP_FRAC);
        end
        else
        begin
            neg      = float_bits[31];
            expf     = {3'd0, float_bits[30:23]};
            frac     = {29'd0, float_bits[22:0]};
            exp_ones = (float_bits[30:23] == 8'hFF);
            smax     = {32'd0, 32'h7FFF_FFFF};
            mag      = {40'd0, 1'b1, float_bits[22:0]};
            e_norm   = $signed({2'b00, expf}) - 13'(SP_BIAS + SP_FRAC);
            e_sub    = 13'(1 - SP_BIAS - SP_FRAC);
        end
    end

    // Classify and form the result
    always_comb
    begin
        significand_out = '0;
        exponent_out    = '0;
        if (exp_ones)
        begin
            if (frac == '0)
                significand_out = neg ? ~smax : smax;
            else
                significand_out = ~smax + 64'd1;
        end
        else if (expf == '0)
        begin
            if (frac != '0)
            begin
                exponent_out    = e_sub[EXPO_W-1:0];
                significand_out = neg ? (64'd0 - {12'd0, frac}) : {12'd0, frac};
            end
        end
        else
        begin
            exponent_out    = e_norm[EXPO_W-1:0];
            significand_out = neg ? (64'd0 - mag) : mag;
        end
    end

endmodule

FILE: rtl/fsec_pack.sv
// ----------------------------------------------------------------------------
// fsec_pack
// Rounds a signed significand to the format and scales it by 2^exponent.
// ----------------------------------------------------------------------------
module fsec_pack
    import fsec_pkg::*;
(
    input  logic                      precision,
    input  logic signed [SIG_W-1:0]   significand_in,
    input  logic signed [EXPI_W-1:0]  exponent_in,
    output logic [FLOAT_W-1:0]        float_out
);

    // Position of the highest set bit plus one
    function automatic logic [6:0] bit_len(input logic [63:0] v);
        logic [6:0] n;
        n = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
                n = 7'(i + 1);
        end
        return n;
    endfunction

    // Right shift with round to nearest, ties to even
    function automatic logic [63:0] rne_shr(input logic [63:0] v, input logic [15:0] sh);
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic [5:0]  s;
        s    = sh[5:0];
        q    = v >> s;
        rem  = v & ((64'd1 << s) - 64'd1);
        half = 64'd1 << (s - 6'd1);
        if (sh == 16'd0)
            q = v;
        else if (sh > 16'd64)
            q = '0;
        else if (sh == 16'd64)
            q = {63'd0, (v > 64'h8000_0000_0000_0000)};
        else if (rem > half || (rem == half && q[0]))
            q = q + 64'd1;
        return q;
    endfunction

    logic [63:0] sig64;
    logic        neg;
    logic [63:0] mag;
    logic [6:0]  p;
    logic [5:0]  fw;
    logic signed [18:0] bias;
    logic signed [18:0] emax;
    logic [6:0]  len;
    logic [6:0]  sh;
    logic [63:0] m_r;
    logic signed [18:0] e_r;
    logic [6:0]  len_r;
    logic signed [18:0] biased;
    logic signed [18:0] k;
    logic signed [18:0] nk;
    logic [63:0] sign_bit;
    logic [63:0] mant;
    logic [63:0] frac_mask;
    logic [63:0] packed_val;
    logic        code_min;
    logic        code_max;
    logic        code_nan;

    // Select format and detect reserved codes
    always_comb
    begin
        if (precision)
        begin
            sig64    = significand_in;
            p        = 7'(DP_FRAC + 1);
            fw       = 6'(DP_FRAC);
            bias     = 19'(DP_BIAS);
            emax     = 19'((1 << DP_EXPW) - 1);
            sign_bit = 64'd1 << 63;
            code_min = (significand_in == 64'h8000_0000_0000_0000);
            code_max = (significand_in == 64'h7FFF_FFFF_FFFF_FFFF);
            code_nan = (significand_in == 64'h8000_0000_0000_0001);
        end
        else
        begin
            sig64    = {{32{significand_in[31]}}, significand_in[31:0]};
            p        = 7'(SP_FRAC + 1);
            fw       = 6'(SP_FRAC);
            bias     = 19'(SP_BIAS);
            emax     = 19'((1 << SP_EXPW) - 1);
            sign_bit = 64'd1 << 31;
            code_min = (significand_in[31:0] == 32'h8000_0000);
            code_max = (significand_in[31:0] == 32'h7FFF_FFFF);
            code_nan = (significand_in[31:0] == 32'h8000_0001);
        end
        neg      = sig64[63];
        mag      = neg ? (64'd0 - sig64) : sig64;
    end

    // Round to precision, then place into normal, subnormal or overflow
    always_comb
    begin
        len = bit_len(mag);
        sh  = (len > p) ? (len - p) : 7'd0;
        m_r = rne_shr(mag, {9'd0, sh});
        e_r = 19'(exponent_in) + $signed({12'd0, sh});
        len_r  = bit_len(m_r);
        biased = $signed({12'd0, len_r}) - 19'sd1 + e_r + bias;
        k      = e_r + bias + $signed({12'd0, p}) - 19'sd2;
        nk     = 19'sd0 - k;
        frac_mask = (64'd1 << fw) - 64'd1;
        mant   = (len_r > p) ? (m_r >> 1) : (m_r << (p - len_r));
        if (biased >= emax)
            packed_val = 64'(emax) << fw;
        else if (biased >= 19'sd1)
            packed_val = (64'(biased) << fw) | (mant & frac_mask);
        else if (k >= 19'sd0)
            packed_val = m_r << k[5:0];
        else
            packed_val = rne_shr(m_r, nk[15:0]);
        if (neg)
            packed_val = packed_val | sign_bit;
    end

    // Apply reserved codes
    always_comb
    begin
        if (code_min)
            float_out = precision ? 64'hFFF0_0000_0000_0000 : 64'h0000_0000_FF80_0000;
        else if (code_max)
            float_out = precision ? 64'h7FF0_0000_0000_0000 : 64'h0000_0000_7F80_0000;
        else if (code_nan)
            float_out = precision ? 64'h7FF8_0000_0000_0000 : 64'h0000_0000_7FC0_0000;
        else if (sig64 == '0)
            float_out = '0;
        else
            float_out = packed_val;
    end

endmodule

FILE: rtl/float_significand_exponent_codec_core.sv
// ----------------------------------------------------------------------------
// float_significand_exponent_codec_core
// IEEE binary32/binary64 pack and unpack between bit patterns and
// (significand, exponent) pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel; tuser selects op (bit 0: 0 unpack,
//   1 pack) and precision (bit 1: 0 binary32, 1 binary64). Each request
//   yields exactly one result on the m_ channel.
//   The request lands in the input register at the accepting edge, and the
//   pack/unpack logic then loads the result register, which raises m_tvalid.
//   Throughput is one request per cycle; both registers advance together
//   whenever the result register is empty or being taken.
//   When the receiver stalls, the result and the request behind it hold,
//   and s_tready drops until m_tready returns.
//   Reset clears both valid flags; no request or result is in flight after.
//   Unpack returns float_out zero; pack returns significand and exponent zero.
// ----------------------------------------------------------------------------
module float_significand_exponent_codec_core
    import fsec_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // float_bits[63:0], significand_in[127:64], exponent_in[143:128]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // op[0], precision[1]
    input  logic [S_TUSER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // float_out[63:0], significand_out[127:64], exponent_out[139:128], zero[143:140]
    output logic [M_TDATA_W-1:0]  m_tdata
);

    logic                      in_valid_reg;
    logic [S_TDATA_W-1:0]      in_data_reg;
    logic [S_TUSER_W-1:0]      in_user_reg;
    logic                      out_valid_reg;
    logic [M_TDATA_W-1:0]      out_data_reg;
    logic [M_TDATA_W-1:0]      out_data_next;
    logic                      advance;
    logic [FLOAT_W-1:0]        pk_float;
    logic signed [SIG_W-1:0]   up_sig;
    logic signed [EXPO_W-1:0]  up_exp;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    fsec_unpack u_unpack (
        .precision       (in_user_reg[1]),
        .float_bits      (in_data_reg[63:0]),
        .significand_out (up_sig),
        .exponent_out    (up_exp)
    );

    fsec_pack u_pack (
        .precision      (in_user_reg[1]),
        .significand_in (in_data_reg[127:64]),
        .exponent_in    (in_data_reg[143:128]),
        .float_out      (pk_float)
    );

    // Select result by operation
    always_comb
    begin
        if (in_user_reg[0] == OP_PACK)
            out_data_next = {4'd0, 12'd0, 64'd0, pk_float};
        else
            out_data_next = {4'd0, up_exp, up_sig, 64'd0};
    end

    // Advance valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg  <= s_tvalid;
            out_valid_reg <= in_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (s_tvalid)
            begin
                in_data_reg <= s_tdata;
                in_user_reg <= s_tuser;
            end
            if (in_valid_reg)
                out_data_reg <= out_data_next;
        end
    end

    // A result never carries both a packed pattern and an unpacked significand
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[63:0] == '0 || m_tdata[139:64] == '0))
        else $error("result mixes pack and unpack fields");

    // Padding bits stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[143:140] == 4'd0)
        else $error("result padding not zero");

    // An accepted request occupies the input stage next cycle
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("accepted request lost");

    // A request in the input stage moves to the result when allowed
    a_move: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && advance) |=> m_tvalid)
        else $error("request dropped between stages");

endmodule
